// File: rtl/vpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpd_pkg
// Types and constants shared by the varint packet deframer.
// ----------------------------------------------------------------------------
package vpd_pkg;

    localparam int unsigned ByteW    = 8;
    localparam int unsigned WordW    = 32;
    localparam int unsigned LenW     = 31;
    localparam int unsigned GroupW   = 3;
    localparam int unsigned MaxGroup = 4;

    localparam logic [7:0] GroupMask = 8'h7F;
    localparam logic [7:0] MoreMask  = 8'h80;
    localparam logic [WordW-1:0] IdMinusOne = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        PH_LEN = 2'd0,
        PH_ID  = 2'd1,
        PH_PAY = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ERR_LEN_LONG  = 3'd0,
        ERR_LEN_NEG   = 3'd1,
        ERR_ID_LONG   = 3'd2,
        ERR_ID_NEG1   = 3'd3,
        ERR_LEN_SHORT = 3'd4
    } err_t;

    typedef struct packed {
        kind_t                    kind;
        logic signed [WordW-1:0]  packet_id;
        logic [LenW-1:0]          payload_length;
        logic [ByteW-1:0]         data_byte;
        logic                     last;
        err_t                     error_code;
    } result_t;

endpackage

// File: rtl/vpd_byte_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpd_byte_if / vpd_result_if
// Valid/ready channels for received bytes and for deframer results.
// ----------------------------------------------------------------------------
interface vpd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface vpd_result_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic signed [31:0] packet_id;
    logic [30:0]        payload_length;
    logic [7:0]         data_byte;
    logic               last;
    logic [2:0]         error_code;

    modport source (output valid, output kind, output packet_id, output payload_length,
                    output data_byte, output last, output error_code, input ready);
    modport sink (input valid, input kind, input packet_id, input payload_length,
                  input data_byte, input last, input error_code, output ready);
endinterface

// File: rtl/vpd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpd_parser
// Framing state and single-beat varint decode; one byte per step.
// ----------------------------------------------------------------------------
module vpd_parser
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       rx_byte,
    output logic             res_valid,
    output vpd_pkg::result_t res
);

    vpd_pkg::phase_t  phase_reg, phase_next;
    logic [31:0]      acc_reg, acc_next;
    logic [2:0]       gc_reg, gc_next;
    logic [31:0]      flen_reg, flen_next;
    logic [30:0]      left_reg, left_next;

    logic [31:0]      placed;
    logic [31:0]      acc_new;
    logic             more;
    logic             too_long;
    logic [3:0]       nbytes;
    logic [31:0]      diff;
    logic [30:0]      left_dec;

    // group k lands at bit 7*k, bits above 31 drop off
    always_comb
    begin
        case (gc_reg)
            3'd0:    placed = {25'd0, rx_byte[6:0]};
            3'd1:    placed = {18'd0, rx_byte[6:0], 7'd0};
            3'd2:    placed = {11'd0, rx_byte[6:0], 14'd0};
            3'd3:    placed = {4'd0, rx_byte[6:0], 21'd0};
            3'd4:    placed = {rx_byte[3:0], 28'd0};
            default: placed = '0;
        endcase
    end

    assign acc_new  = acc_reg | (placed & {25'd0, vpd_pkg::GroupMask[6:0]} << 0 | placed);
    assign more     = |(rx_byte & vpd_pkg::MoreMask);
    assign too_long = more && (gc_reg >= 3'(vpd_pkg::MaxGroup));
    assign nbytes   = {1'b0, gc_reg} + 4'd1;
    assign diff     = flen_reg - {28'd0, nbytes};
    assign left_dec = (left_reg != '0) ? left_reg - 31'd1 : '0;

    // result and next state for the held byte; state moves only on step
    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        gc_next    = gc_reg;
        flen_next  = flen_reg;
        left_next  = left_reg;
        res_valid  = 1'b0;
        res        = '0;
        res.kind       = vpd_pkg::KIND_HEADER;
        res.error_code = vpd_pkg::ERR_LEN_LONG;

        case (phase_reg)
            vpd_pkg::PH_PAY:
            begin
                res_valid     = 1'b1;
                res.kind      = vpd_pkg::KIND_PAYLOAD;
                res.data_byte = rx_byte;
                left_next     = left_dec;
                if (left_dec == '0)
                begin
                    res.last   = 1'b1;
                    phase_next = vpd_pkg::PH_LEN;
                    acc_next   = '0;
                    gc_next    = '0;
                end
            end
            vpd_pkg::PH_ID:
            begin
                if (too_long)
                begin
                    res_valid      = 1'b1;
                    res.kind       = vpd_pkg::KIND_ERROR;
                    res.error_code = vpd_pkg::ERR_ID_LONG;
                    phase_next     = vpd_pkg::PH_LEN;
                    acc_next       = '0;
                    gc_next        = '0;
                end
                else if (more)
                begin
                    acc_next = acc_new;
                    gc_next  = gc_reg + 3'd1;
                end
                else if (acc_new == vpd_pkg::IdMinusOne)
                begin
                    res_valid      = 1'b1;
                    res.kind       = vpd_pkg::KIND_ERROR;
                    res.error_code = vpd_pkg::ERR_ID_NEG1;
                    phase_next     = vpd_pkg::PH_LEN;
                    acc_next       = '0;
                    gc_next        = '0;
                end
                else if (flen_reg < {28'd0, nbytes})
                begin
                    res_valid      = 1'b1;
                    res.kind       = vpd_pkg::KIND_ERROR;
                    res.error_code = vpd_pkg::ERR_LEN_SHORT;
                    phase_next     = vpd_pkg::PH_LEN;
                    acc_next       = '0;
                    gc_next        = '0;
                end
                else
                begin
                    res_valid          = 1'b1;
                    res.kind           = vpd_pkg::KIND_HEADER;
                    res.packet_id      = acc_new;
                    res.payload_length = diff[30:0];
                    res.last           = (diff[30:0] == '0);
                    left_next          = diff[30:0];
                    phase_next         = (diff[30:0] == '0) ? vpd_pkg::PH_LEN
                                                            : vpd_pkg::PH_PAY;
                    acc_next           = '0;
                    gc_next            = '0;
                end
            end
            default:
            begin
                // length phase, unused code behaves the same
                phase_next = vpd_pkg::PH_LEN;
                if (too_long)
                begin
                    res_valid      = 1'b1;
                    res.kind       = vpd_pkg::KIND_ERROR;
                    res.error_code = vpd_pkg::ERR_LEN_LONG;
                    acc_next       = '0;
                    gc_next        = '0;
                end
                else if (more)
                begin
                    acc_next = acc_new;
                    gc_next  = gc_reg + 3'd1;
                end
                else if (acc_new[31])
                begin
                    res_valid      = 1'b1;
                    res.kind       = vpd_pkg::KIND_ERROR;
                    res.error_code = vpd_pkg::ERR_LEN_NEG;
                    acc_next       = '0;
                    gc_next        = '0;
                end
                else
                begin
                    flen_next  = acc_new;
                    acc_next   = '0;
                    gc_next    = '0;
                    phase_next = vpd_pkg::PH_ID;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= vpd_pkg::PH_LEN;
            acc_reg   <= '0;
            gc_reg    <= '0;
            flen_reg  <= '0;
            left_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            gc_reg    <= gc_next;
            flen_reg  <= flen_next;
            left_reg  <= left_next;
        end
    end

endmodule

// File: rtl/varint_packet_deframer.sv
`timescale 1ns / 1ps
// a byte is registered on accept and, if it yields a result, that result is registered
// when the parser steps on that byte; output back-pressure can stall the step
// throughput: one byte per cycle while the output is free or the byte yields no result,
// set by the single-step parser between the input register and the result register
// reset: asynchronous, clears framing state; the parser waits for a length varint
// ----------------------------------------------------------------------------
// varint_packet_deframer
// Splits a byte stream into varint length-prefixed packets: header, payload
// bytes with a last mark, or a framing error.
// ----------------------------------------------------------------------------
module varint_packet_deframer
(
    input  logic         clk,
    input  logic         rst_n,
    vpd_byte_if.sink     din,
    vpd_result_if.source dout
);

    logic             in_valid_reg, in_valid_next;
    logic [7:0]       byte_reg;
    logic             out_valid_reg, out_valid_next;
    vpd_pkg::result_t res_reg;

    logic             step;
    logic             res_valid;
    vpd_pkg::result_t res;
    logic             out_free;

    assign out_free = !out_valid_reg || dout.ready;
    // a byte with no result never waits on the output side
    assign step     = in_valid_reg && (out_free || !res_valid);
    assign din.ready = !in_valid_reg || step;

    vpd_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .rx_byte   (byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (din.valid && din.ready)
            in_valid_next = 1'b1;
        else if (step)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (step && res_valid)
            out_valid_next = 1'b1;
        else if (dout.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (din.valid && din.ready)
            byte_reg <= din.rx_byte;
        if (step && res_valid)
            res_reg <= res;
    end

    assign dout.valid          = out_valid_reg;
    assign dout.kind           = res_reg.kind;
    assign dout.packet_id      = res_reg.packet_id;
    assign dout.payload_length = res_reg.payload_length;
    assign dout.data_byte      = res_reg.data_byte;
    assign dout.last           = res_reg.last;
    assign dout.error_code     = res_reg.error_code;

endmodule
